FILE: src/ifmt_pkg.sv
`timescale 1ns / 1ps
package ifmt_pkg;

  localparam int MAX_WIDTH  = 60;
  localparam int VALUE_W    = 64;
  localparam int NDIG       = 20;
  localparam int DIG_W      = $clog2(NDIG);
  localparam int BCD_W      = NDIG * 4;
  localparam int CNT_W      = ($clog2(MAX_WIDTH + 1) > 6) ? $clog2(MAX_WIDTH + 1) : 6;
  localparam int CONV_STEPS = VALUE_W / 2;
  localparam int STEP_W     = $clog2(CONV_STEPS);

  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_LHEX = 3'd2;
  localparam logic [2:0] KIND_UHEX = 3'd3;
  localparam logic [2:0] KIND_PTR  = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  typedef struct packed {
    logic [CNT_W-1:0] px;
    logic [CNT_W-1:0] spc_pre;
    logic [CNT_W-1:0] sign;
    logic [CNT_W-1:0] zpad;
    logic [CNT_W-1:0] digs;
    logic [CNT_W-1:0] spc_post;
  } plan_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'h0, d};
    end else if (upper) begin
      c = CH_UA + {4'h0, d} - 8'd10;
    end else begin
      c = CH_LA + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

FILE: src/integer_field_formatter.sv
`timescale 1ns / 1ps
// Formats one integer conversion request (signed or unsigned decimal, lower or upper hex, or
// pointer) into ASCII characters, one character per output transfer, with tlast on the final
// character. One request is taken at a time: in_tready is high only while the block is idle,
// and the next request is accepted while the final character still waits in the output
// register. A request is registered, then prepared and planned in the PREP and LEN states,
// after which its characters follow at one per cycle while the output is not stalled and the
// generator is not moving between segments. Decimal requests first pass through the
// binary-to-BCD converter, a dedicated shift-and-add-3 unit that consumes two value bits per
// cycle and then registers its done flag to hand over the digits. The character generator
// walks six field segments (prefix, leading spaces, sign, zero padding, digits, trailing
// spaces) and pauses, emitting nothing, when it moves on from each segment before the last
// nonempty one.
module integer_field_formatter import ifmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value[63:0], conv_kind[66:64], is_long[67], field_width[73:68], pad_zeros[74],
  // align_left[75], unused[79:76]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_char[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CONV,
    ST_LEN,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [2:0]          kind_r, kind_nxt;
  logic                lng_r, lng_nxt;
  logic [CNT_W-1:0]    w_r, w_nxt;
  logic                zp_r, zp_nxt;
  logic                la_r, la_nxt;
  logic                neg_r, neg_nxt;
  logic                ptr_r, ptr_nxt;
  logic                upper_r, upper_nxt;
  logic [NDIG-1:0][3:0] digits_r, digits_nxt;

  logic [VALUE_W-1:0]  ext_c, mag_c;
  logic                neg_c, hex_c;
  logic [CNT_W-1:0]    w_in, len_c, width_eff, total_c, pad_c;
  plan_t               plan_c;
  logic                conv_start, conv_done, gen_start, gen_done;
  logic [BCD_W-1:0]    conv_bcd;
  logic                accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign w_in      = CNT_W'(in_tdata[73:68]);

  always_comb begin
    if (kind_r == KIND_PTR || lng_r) begin
      ext_c = value_r;
    end else if (kind_r == KIND_SDEC && value_r[31]) begin
      ext_c = {32'hffff_ffff, value_r[31:0]};
    end else begin
      ext_c = {32'h0000_0000, value_r[31:0]};
    end
    neg_c = (kind_r == KIND_SDEC) && ext_c[VALUE_W-1];
    mag_c = neg_c ? (~ext_c + 1'b1) : ext_c;
    hex_c = (kind_r == KIND_LHEX) || (kind_r == KIND_UHEX) || (kind_r == KIND_PTR);
  end

  always_comb begin
    len_c = CNT_W'(1);
    for (int i = 1; i < NDIG; i++) begin
      if (digits_r[i] != 4'h0) begin
        len_c = CNT_W'(i + 1);
      end
    end
    if (ptr_r) begin
      width_eff = (w_r > CNT_W'(2)) ? (w_r - CNT_W'(2)) : '0;
    end else begin
      width_eff = w_r;
    end
    total_c = len_c + CNT_W'(neg_r);
    pad_c   = (width_eff > total_c) ? (width_eff - total_c) : '0;
    plan_c.px       = ptr_r ? CNT_W'(2) : '0;
    plan_c.spc_pre  = (!la_r && !zp_r) ? pad_c : '0;
    plan_c.sign     = CNT_W'(neg_r);
    plan_c.zpad     = (!la_r && zp_r) ? pad_c : '0;
    plan_c.digs     = len_c;
    plan_c.spc_post = la_r ? pad_c : '0;
  end

  assign conv_start = (state_r == ST_PREP) && !hex_c;
  assign gen_start  = (state_r == ST_LEN);

  always_comb begin
    state_nxt  = state_r;
    value_nxt  = value_r;
    kind_nxt   = kind_r;
    lng_nxt    = lng_r;
    w_nxt      = w_r;
    zp_nxt     = zp_r;
    la_nxt     = la_r;
    neg_nxt    = neg_r;
    ptr_nxt    = ptr_r;
    upper_nxt  = upper_r;
    digits_nxt = digits_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          value_nxt = in_tdata[63:0];
          kind_nxt  = (in_tdata[66:64] > KIND_PTR) ? KIND_UDEC : in_tdata[66:64];
          lng_nxt   = in_tdata[67];
          w_nxt     = (w_in > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : w_in;
          zp_nxt    = in_tdata[74];
          la_nxt    = in_tdata[75];
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        neg_nxt   = neg_c;
        ptr_nxt   = (kind_r == KIND_PTR);
        upper_nxt = (kind_r == KIND_UHEX);
        if (hex_c) begin
          digits_nxt = {{(BCD_W - VALUE_W){1'b0}}, mag_c};
          state_nxt  = ST_LEN;
        end else begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          digits_nxt = conv_bcd;
          state_nxt  = ST_LEN;
        end
      end
      ST_LEN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (gen_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    value_r  <= value_nxt;
    kind_r   <= kind_nxt;
    lng_r    <= lng_nxt;
    w_r      <= w_nxt;
    zp_r     <= zp_nxt;
    la_r     <= la_nxt;
    neg_r    <= neg_nxt;
    ptr_r    <= ptr_nxt;
    upper_r  <= upper_nxt;
    digits_r <= digits_nxt;
  end

  ifmt_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .bin   (mag_c),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  ifmt_char_gen u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (gen_start),
    .plan       (plan_c),
    .digits     (digits_r),
    .upper      (upper_r),
    .done       (gen_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: src/ifmt_bcd_conv.sv
`timescale 1ns / 1ps
module ifmt_bcd_conv import ifmt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] bin,
  output logic               done,
  output logic [BCD_W-1:0]   bcd
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;

  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                               input logic bit_in);
    logic [BCD_W-1:0] t;
    t = b;
    for (int i = 0; i < NDIG; i++) begin
      if (t[i*4 +: 4] >= 4'd5) begin
        t[i*4 +: 4] = t[i*4 +: 4] + 4'd3;
      end
    end
    return {t[BCD_W-2:0], bit_in};
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      bin_nxt  = bin;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt  = dd_step(dd_step(bcd_r, bin_r[VALUE_W-1]), bin_r[VALUE_W-2]);
      bin_nxt  = {bin_r[VALUE_W-3:0], 2'b00};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(CONV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

FILE: src/ifmt_char_gen.sv
`timescale 1ns / 1ps
module ifmt_char_gen import ifmt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  plan_t                plan,
  input  logic [NDIG-1:0][3:0] digits,
  input  logic                 upper,
  output logic                 done,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  typedef enum logic [2:0] {
    SEG_PX,
    SEG_SPC_PRE,
    SEG_SIGN,
    SEG_ZPAD,
    SEG_DIGS,
    SEG_SPC_POST
  } seg_t;

  seg_t             seg_r, seg_nxt;
  logic             active_r, active_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  plan_t            plan_r, plan_nxt;
  logic             upper_r, upper_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [7:0]       out_tdata_r, out_tdata_nxt;
  logic             out_tlast_r, out_tlast_nxt;
  logic             emit;
  logic [DIG_W-1:0] dig_idx;
  logic [7:0]       ch;

  function automatic seg_t next_seg(input seg_t s);
    seg_t n;
    case (s)
      SEG_PX:      n = SEG_SPC_PRE;
      SEG_SPC_PRE: n = SEG_SIGN;
      SEG_SIGN:    n = SEG_ZPAD;
      SEG_ZPAD:    n = SEG_DIGS;
      SEG_DIGS:    n = SEG_SPC_POST;
      default:     n = SEG_SPC_POST;
    endcase
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] seg_count(input seg_t s, input plan_t p);
    logic [CNT_W-1:0] c;
    case (s)
      SEG_PX:       c = p.px;
      SEG_SPC_PRE:  c = p.spc_pre;
      SEG_SIGN:     c = p.sign;
      SEG_ZPAD:     c = p.zpad;
      SEG_DIGS:     c = p.digs;
      SEG_SPC_POST: c = p.spc_post;
      default:      c = '0;
    endcase
    return c;
  endfunction

  assign dig_idx = DIG_W'(cnt_r - 1'b1);
  assign emit    = active_r && (cnt_r != '0) && (!out_tvalid_r || out_tready);
  assign done    = emit && (left_r == CNT_W'(1));

  always_comb begin
    case (seg_r)
      SEG_PX:       ch = (cnt_r == CNT_W'(2)) ? CH_ZERO : CH_X;
      SEG_SPC_PRE:  ch = CH_SPACE;
      SEG_SIGN:     ch = CH_MINUS;
      SEG_ZPAD:     ch = CH_ZERO;
      SEG_DIGS:     ch = hex_char(digits[dig_idx], upper_r);
      SEG_SPC_POST: ch = CH_SPACE;
      default:      ch = CH_SPACE;
    endcase
  end

  always_comb begin
    seg_nxt        = seg_r;
    active_nxt     = active_r;
    cnt_nxt        = cnt_r;
    left_nxt       = left_r;
    plan_nxt       = plan_r;
    upper_nxt      = upper_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (start) begin
      active_nxt = 1'b1;
      plan_nxt   = plan;
      upper_nxt  = upper;
      seg_nxt    = SEG_PX;
      cnt_nxt    = plan.px;
      left_nxt   = plan.px + plan.spc_pre + plan.sign + plan.zpad + plan.digs
                   + plan.spc_post;
    end else if (active_r) begin
      if (cnt_r == '0) begin
        seg_nxt = next_seg(seg_r);
        cnt_nxt = seg_count(next_seg(seg_r), plan_r);
      end else if (emit) begin
        out_tvalid_nxt = 1'b1;
        out_tdata_nxt  = ch;
        out_tlast_nxt  = (left_r == CNT_W'(1));
        cnt_nxt        = cnt_r - 1'b1;
        left_nxt       = left_r - 1'b1;
        if (left_r == CNT_W'(1)) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      seg_r        <= SEG_PX;
      cnt_r        <= '0;
      left_r       <= '0;
    end else begin
      active_r     <= active_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      seg_r        <= seg_nxt;
      cnt_r        <= cnt_nxt;
      left_r       <= left_nxt;
    end
    plan_r      <= plan_nxt;
    upper_r     <= upper_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

FILE: src/ifmt_checker.sv
`timescale 1ns / 1ps
module ifmt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transfer changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again while a request is in progress");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == 8'h20) || (out_tdata == 8'h2d) || (out_tdata == 8'h78) ||
                   ((out_tdata >= 8'h30) && (out_tdata <= 8'h39)) ||
                   ((out_tdata >= 8'h41) && (out_tdata <= 8'h46)) ||
                   ((out_tdata >= 8'h61) && (out_tdata <= 8'h66)))
    else $error("character outside the formatter alphabet");

endmodule

bind integer_field_formatter ifmt_checker u_ifmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
